>>> design/rmst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the range minimum segment tree.
// No dependencies.
package rmst_pkg;
	localparam int DEF_MAX_ELEMENTS = 1024;
	localparam int RESET_COUNT = 1024;
	localparam int CNT_PORT_W = 11;
	localparam int IDX_W = 10;
	localparam int VAL_W = 32;

	localparam logic OP_ASSIGN = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// one clipped item handed from the front end to the tree engine
	typedef struct packed {
		logic op;
		logic empty;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic [VAL_W-1:0] value;
	} cmd_t;
endpackage

>>> design/range_min_segment_tree.sv
`timescale 1ns / 1ps
// Range minimum segment tree, top level. Depends on rmst_pkg and submodules.
// Query: bottom-up walk over the tree levels (one node memory read port).
// Assign: each element in the range is written and its leaf path updated.
// Empty ranges answer without a tree walk. One item in the tree engine at a time.
// After reset and after each element_count write, a clearing pass sets all nodes
// to all ones; no item is taken meanwhile.
module range_min_segment_tree import rmst_pkg::*; #(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CNT_PORT_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic op,
	input  logic [IDX_W-1:0] range_low,
	input  logic [IDX_W-1:0] range_high,
	input  logic [VAL_W-1:0] new_value,
	output logic out_valid,
	input  logic out_ready,
	output logic [VAL_W-1:0] min_value,
	output logic found
);
	logic clearing, f_valid, f_ready, b_valid, b_ready;
	cmd_t f_cmd, b_cmd;

	rmst_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_data, .in_valid, .in_ready,
		.op, .range_low, .range_high, .new_value, .clearing,
		.q_ready(f_ready), .q_valid(f_valid), .q_cmd(f_cmd)
	);

	rmst_cmd_fifo u_fifo (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_cmd(f_cmd),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_cmd(b_cmd)
	);

	rmst_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
		.clk, .arst_n, .cfg_we, .clearing,
		.cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
		.out_valid, .out_ready, .min_value, .found
	);
endmodule

>>> design/rmst_front.sv
`timescale 1ns / 1ps
// Front end: element count register, range clipping and command build.
// Depends on rmst_pkg.
module rmst_front import rmst_pkg::*; #(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CNT_PORT_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic op,
	input  logic [IDX_W-1:0] range_low,
	input  logic [IDX_W-1:0] range_high,
	input  logic [VAL_W-1:0] new_value,
	input  logic clearing,
	input  logic q_ready,
	output logic q_valid,
	output cmd_t q_cmd
);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int IW = ((CW > IDX_W) ? CW : IDX_W) + 1;
	localparam int RST_N = (RESET_COUNT > MAX_ELEMENTS) ? MAX_ELEMENTS : RESET_COUNT;

	logic [CW-1:0] count_q;
	logic [IW-1:0] last, hi_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(RST_N);
		end else if (cfg_we) begin
			if (cfg_data == '0)
				count_q <= CW'(1);
			else if (32'(cfg_data) > 32'(MAX_ELEMENTS))
				count_q <= CW'(MAX_ELEMENTS);
			else
				count_q <= CW'(cfg_data);
		end
	end

	always_comb begin
		last = IW'(count_q) - IW'(1);
		hi_c = (IW'(range_high) > last) ? last : IW'(range_high);
		q_cmd.op = op;
		q_cmd.empty = IW'(range_low) > hi_c;
		q_cmd.lo = range_low;
		q_cmd.hi = IDX_W'(hi_c);
		q_cmd.value = new_value;
	end

	assign in_ready = q_ready && !clearing && !cfg_we;
	assign q_valid = in_valid && !clearing && !cfg_we;
endmodule

>>> design/rmst_cmd_fifo.sv
`timescale 1ns / 1ps
// Two-entry command queue between front end and tree engine.
// Depends on rmst_pkg.
module rmst_cmd_fifo import rmst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_cmd,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_cmd
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_cmd = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

>>> design/rmst_back.sv
`timescale 1ns / 1ps
// Tree engine: node memory, clearing pass, bottom-up query and leaf-path
// assign sequencer, result register. Depends on rmst_pkg.
module rmst_back import rmst_pkg::*; #(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	output logic clearing,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic out_valid,
	input  logic out_ready,
	output logic [VAL_W-1:0] min_value,
	output logic found
);
	localparam int LW = $clog2(MAX_ELEMENTS);
	localparam int NW = LW + 1;
	localparam int QW = NW + 1;
	localparam int DEPTH = 2 << LW;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_QRY   = 3'd2;
	localparam logic [2:0] S_LEAF  = 3'd3;
	localparam logic [2:0] S_ARD   = 3'd4;
	localparam logic [2:0] S_AUP   = 3'd5;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;
	logic [NW-1:0] raddr, waddr;
	logic re, we;
	logic [VAL_W-1:0] wdata;

	logic [2:0] state_q;
	logic [NW-1:0] clr_q, node_q;
	logic [QW-1:0] l_q, r_q;
	logic [LW-1:0] leaf_q, hi_q;
	logic [VAL_W-1:0] val_q, acc_q;
	logic pend_q;
	logic [VAL_W-1:0] acc_nx, up_min;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign clearing = state_q == S_CLEAR;
	assign cmd_ready = state_q == S_IDLE && !out_valid;
	assign acc_nx = (pend_q && rdata_q < acc_q) ? rdata_q : acc_q;
	assign up_min = (rdata_q < acc_q) ? rdata_q : acc_q;

	always_comb begin
		re = 1'b0;
		raddr = '0;
		we = 1'b0;
		waddr = '0;
		wdata = '1;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
			end
			S_QRY: begin
				if (l_q < r_q) begin
					if (l_q[0]) begin
						re = 1'b1;
						raddr = l_q[NW-1:0];
					end else if (r_q[0]) begin
						re = 1'b1;
						raddr = NW'(r_q - QW'(1));
					end
				end
			end
			S_LEAF: begin
				we = 1'b1;
				waddr = {1'b1, leaf_q};
				wdata = val_q;
			end
			S_ARD: begin
				re = node_q != NW'(1);
				raddr = node_q ^ NW'(1);
			end
			S_AUP: begin
				we = 1'b1;
				waddr = node_q >> 1;
				wdata = up_min;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			pend_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == {NW{1'b1}})
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid && !out_valid) begin
						val_q <= cmd.value;
						leaf_q <= LW'(cmd.lo);
						hi_q <= LW'(cmd.hi);
						acc_q <= '1;
						l_q <= QW'(DEPTH / 2) + QW'(LW'(cmd.lo));
						r_q <= QW'(DEPTH / 2) + QW'(LW'(cmd.hi)) + QW'(1);
						if (cmd.empty) begin
							out_valid <= 1'b1;
							min_value <= '0;
							found <= 1'b0;
						end else if (cmd.op == OP_QUERY) begin
							state_q <= S_QRY;
						end else begin
							state_q <= S_LEAF;
						end
					end
				end
				S_QRY: begin
					acc_q <= acc_nx;
					if (l_q < r_q) begin
						if (l_q[0]) begin
							l_q <= l_q + QW'(1);
							pend_q <= 1'b1;
						end else if (r_q[0]) begin
							r_q <= r_q - QW'(1);
							pend_q <= 1'b1;
						end else begin
							l_q <= l_q >> 1;
							r_q <= r_q >> 1;
						end
					end else if (!pend_q) begin
						out_valid <= 1'b1;
						min_value <= acc_q;
						found <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LEAF: begin
					node_q <= {1'b1, leaf_q};
					acc_q <= val_q;
					state_q <= S_ARD;
				end
				S_ARD: begin
					if (node_q == NW'(1)) begin
						if (leaf_q == hi_q) begin
							out_valid <= 1'b1;
							min_value <= '0;
							found <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							leaf_q <= leaf_q + LW'(1);
							state_q <= S_LEAF;
						end
					end else begin
						state_q <= S_AUP;
					end
				end
				S_AUP: begin
					acc_q <= up_min;
					node_q <= node_q >> 1;
					state_q <= S_ARD;
				end
				default: state_q <= S_IDLE;
			endcase
			// new element count reshapes the tree: wipe every node
			if (cfg_we) begin
				state_q <= S_CLEAR;
				clr_q <= '0;
			end
		end
	end
endmodule

>>> design/rmst_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the range minimum segment tree, bound to the top level.
// Depends on rmst_pkg.
module rmst_checker import rmst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [VAL_W-1:0] min_value,
	input logic found
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(min_value) && $stable(found))
		else $error("result changed while stalled");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> min_value == '0)
		else $error("nonzero value without found");
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("input taken during clearing pass");
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_ready)
		else $error("input ready during count write");
endmodule

bind range_min_segment_tree rmst_checker u_rmst_checker (
	.clk, .arst_n, .cfg_we, .in_ready, .out_valid, .out_ready, .min_value, .found
);

>>> verif/tb_range_min_segment_tree.sv
`timescale 1ns / 1ps
// Self-checking testbench for range_min_segment_tree: random and directed assigns
// and queries, checked against a flat per-element minimum model.
// Depends on rmst_pkg and the range_min_segment_tree RTL.
module tb_range_min_segment_tree;
	import rmst_pkg::*;

	typedef struct {
		logic op;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic [VAL_W-1:0] value;
	} rmq_item_t;

	typedef struct {
		logic [VAL_W-1:0] min_value;
		logic found;
	} rmq_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CNT_PORT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = OP_ASSIGN;
	logic [IDX_W-1:0] range_low = '0;
	logic [IDX_W-1:0] range_high = '0;
	logic [VAL_W-1:0] new_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [VAL_W-1:0] min_value;
	logic found;

	rmq_item_t pending_items[$];
	rmq_answer_t expected_answers[$];
	rmq_item_t offered;
	logic [VAL_W-1:0] elements [0:DEF_MAX_ELEMENTS-1];
	int unsigned active_count = RESET_COUNT;
	int fail_count = 0;
	logic long_hold_req = 1'b0;

	range_min_segment_tree DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .range_low(range_low), .range_high(range_high), .new_value(new_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.min_value(min_value), .found(found)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void clear_elements();
		for (int i = 0; i < DEF_MAX_ELEMENTS; i++)
			elements[i] = '1;
	endfunction

	// apply one accepted item to the element store and return its answer
	function automatic rmq_answer_t apply_item(rmq_item_t it);
		rmq_answer_t ans;
		int unsigned hi_c;
		ans.min_value = '0;
		ans.found = 1'b0;
		hi_c = (it.hi > active_count - 1) ? active_count - 1 : it.hi;
		if (it.lo <= hi_c) begin
			if (it.op == OP_ASSIGN) begin
				for (int unsigned i = it.lo; i <= hi_c; i++)
					elements[i] = it.value;
			end else begin
				ans.found = 1'b1;
				ans.min_value = '1;
				for (int unsigned i = it.lo; i <= hi_c; i++)
					if (elements[i] < ans.min_value)
						ans.min_value = elements[i];
			end
		end
		return ans;
	endfunction

	// driver: bursts of transfers separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = $urandom_range(1, 20);
			gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				expected_answers.push_back(apply_item(offered));
			if (in_valid && !in_ready) begin
				// hold the current item
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				offered = pending_items.pop_front();
				op <= offered.op;
				range_low <= offered.lo;
				range_high <= offered.hi;
				new_value <= offered.value;
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern re-chosen periodically, plus one long hold-off
	// counted while a result is waiting
	int rx_cycle = 0;
	int rx_mode = 0;
	int hold_count = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 2);
			if (long_hold_req && hold_count < 600) begin
				if (out_valid)
					hold_count++;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rmq_answer_t exp_ans;
		if (arst_n && out_valid && out_ready) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result min_value=%h found=%b", $time,
					min_value, found);
				fail_count++;
			end else begin
				exp_ans = expected_answers.pop_front();
				if (min_value !== exp_ans.min_value) begin
					$display("%0t: min_value expected %h actual %h", $time,
						exp_ans.min_value, min_value);
					fail_count++;
				end
				if (found !== exp_ans.found) begin
					$display("%0t: found expected %b actual %b", $time,
						exp_ans.found, found);
					fail_count++;
				end
			end
		end
	end

	task automatic push_item(logic o, int lo, int hi, logic [VAL_W-1:0] v);
		rmq_item_t it;
		it.op = o;
		it.lo = IDX_W'(lo);
		it.hi = IDX_W'(hi);
		it.value = v;
		pending_items.push_back(it);
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || in_valid || expected_answers.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_count(logic [CNT_PORT_W-1:0] val);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_count = (val == 0) ? 1 : (val > DEF_MAX_ELEMENTS) ? DEF_MAX_ELEMENTS : val;
		clear_elements();
	endtask

	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 15);
			1: return '1 - $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_random(int n);
		logic o;
		int lo, hi, span;
		for (int k = 0; k < n; k++) begin
			o = $urandom_range(0, 1) ? OP_QUERY : OP_ASSIGN;
			if ($urandom_range(0, 9) == 0)
				lo = $urandom_range(0, DEF_MAX_ELEMENTS - 1);
			else
				lo = $urandom_range(0, active_count - 1);
			if ($urandom_range(0, 9) == 0) begin
				hi = $urandom_range(0, DEF_MAX_ELEMENTS - 1);
				// keep assigns cheap: a wide range only once in a while
				if (o == OP_ASSIGN && hi - lo > 64 && $urandom_range(0, 7) != 0)
					hi = lo + $urandom_range(0, 64);
			end else begin
				span = (o == OP_ASSIGN) ? $urandom_range(0, 8) : $urandom_range(0, 300);
				hi = lo + span;
			end
			if (hi > DEF_MAX_ELEMENTS - 1)
				hi = DEF_MAX_ELEMENTS - 1;
			push_item(o, lo, hi, rand_value());
		end
	endtask

	initial begin
		clear_elements();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// fresh tree, full range, edges and empty ranges
		push_item(OP_QUERY, 0, 1023, 32'h1234);
		push_item(OP_ASSIGN, 0, 1023, 32'h0000_0005);
		push_item(OP_QUERY, 0, 1023, '0);
		push_item(OP_ASSIGN, 1023, 1023, 32'h0000_0000);
		push_item(OP_QUERY, 1000, 1023, '1);
		push_item(OP_ASSIGN, 0, 0, 32'hFFFF_FFFF);
		push_item(OP_QUERY, 0, 0, '0);
		push_item(OP_QUERY, 10, 3, '0);
		push_item(OP_ASSIGN, 7, 2, 32'h0000_0000);
		push_item(OP_QUERY, 0, 9, '0);
		push_item(OP_ASSIGN, 512, 515, 32'h8000_0000);
		push_item(OP_QUERY, 511, 512, '0);
		push_item(OP_QUERY, 1023, 1023, '0);
		push_item(OP_ASSIGN, 341, 682, 32'hAAAA_5555);
		push_item(OP_QUERY, 300, 700, '0);
		push_random(150);

		write_count(11'd1);
		push_item(OP_QUERY, 0, 1023, '0);
		push_item(OP_QUERY, 1, 5, '0);
		push_item(OP_ASSIGN, 0, 1023, 32'h7FFF_FFFF);
		push_item(OP_QUERY, 0, 0, '0);
		push_item(OP_ASSIGN, 1, 1023, 32'h0000_0001);
		push_item(OP_QUERY, 0, 1023, '0);
		push_random(120);

		write_count(11'd0);
		push_random(120);

		write_count(11'd2047);
		push_item(OP_QUERY, 0, 1023, '0);
		long_hold_req <= 1'b1;
		push_random(200);

		write_count(11'd1024);
		push_random(150);
		write_count(11'd2);
		push_random(150);
		write_count(11'd5);
		push_random(150);
		write_count(11'd1000);
		push_random(150);
		write_count(CNT_PORT_W'($urandom_range(3, 1023)));
		push_random(150);

		wait_idle();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#60ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
